### src/mra_pkg.sv
package mra_pkg;

    // Fixed field widths
    localparam int ROW_W   = 7;
    localparam int AREA_W  = 17;

    localparam logic [ROW_W-1:0]  ROW_WIDTH_RESET = 7'd64;
    localparam logic [AREA_W-1:0] AREA_CAP        = 17'h1FFFF;

    // Defaults for the top-level parameters
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 1024;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // One classified cell as it travels from front to back
    typedef struct packed {
        logic cell_bit;
        logic last_cell;
        logic row_end;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_OUT
    } t_back_state;

endpackage

### src/mra_front.sv
module mra_front #(
    parameter int MAX_COLS = mra_pkg::MAX_COLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // cell channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_cell_bit,
    input  logic                     i_last_cell,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [mra_pkg::ROW_W-1:0] i_row_width,
    // queue side
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output mra_pkg::t_item           o_q_item
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int DW   = $clog2(MAX_COLS + 1);
    localparam int CMPW = ((DW > mra_pkg::ROW_W) ? DW : mra_pkg::ROW_W) + 1;

    logic [mra_pkg::ROW_W-1:0] r_row_width;
    logic [CW-1:0]             r_col;
    logic [CW-1:0]             n_col;
    logic [CMPW-1:0]           w_eff;
    logic [CMPW-1:0]           w_col_next;
    logic                      w_row_end;
    logic                      w_accept;

    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= mra_pkg::ROW_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_row_width <= i_row_width;
        end
    end

    // Effective row width: zero reads as one, clamp to MAX_COLS
    always_comb begin
        if (r_row_width == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_row_width) > CMPW'(MAX_COLS)) begin
            w_eff = CMPW'(MAX_COLS);
        end else begin
            w_eff = CMPW'(r_row_width);
        end
    end

    // Classify the beat: does it close a row
    assign w_col_next = CMPW'(r_col) + CMPW'(1);
    assign w_row_end  = i_last_cell || (w_col_next >= w_eff);
    assign w_accept   = i_valid && !i_q_full;

    assign o_ready            = !i_q_full;
    assign o_q_push           = w_accept;
    assign o_q_item.cell_bit  = i_cell_bit;
    assign o_q_item.last_cell = i_last_cell;
    assign o_q_item.row_end   = w_row_end;

    always_comb begin
        n_col = r_col;
        if (w_accept) begin
            n_col = w_row_end ? '0 : CW'(w_col_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

endmodule

### src/mra_queue.sv
module mra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mra_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mra_pkg::t_item o_item
);

    mra_pkg::t_item                r_slot [mra_pkg::QUEUE_DEPTH];
    logic [mra_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [mra_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [mra_pkg::QPTR_W:0]      r_count;
    logic                          w_do_push;
    logic                          w_do_pop;

    assign o_full    = (r_count == (mra_pkg::QPTR_W + 1)'(mra_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_item    = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/mra_back.sv
module mra_back #(
    parameter int MAX_COLS = mra_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mra_pkg::MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // queue side
    input  logic                       i_q_empty,
    input  mra_pkg::t_item             i_q_item,
    output logic                       o_q_pop,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mra_pkg::AREA_W-1:0] o_max_area
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int DW = $clog2(MAX_COLS + 1);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int PW = HW + DW;
    localparam int XW = (PW > mra_pkg::AREA_W) ? PW : mra_pkg::AREA_W;

    // Column heights: memory plus a valid bit per column
    logic [HW-1:0]       r_hmem [MAX_COLS];
    logic [MAX_COLS-1:0] r_hvalid;
    logic [HW-1:0]       r_hrd;
    logic                r_hrd_vld;

    // Stack: memory holds every entry, top and the one below are registered
    logic [CW-1:0] r_smem_s [MAX_COLS];
    logic [HW-1:0] r_smem_h [MAX_COLS];
    logic [CW-1:0] r_below_s;
    logic [HW-1:0] r_below_h;
    logic [CW-1:0] r_top_s, n_top_s;
    logic [HW-1:0] r_top_h, n_top_h;
    logic [DW-1:0] r_depth, n_depth;

    mra_pkg::t_back_state r_state, n_state;
    mra_pkg::t_item       r_item,  n_item;
    logic [CW-1:0]        r_col,   n_col;
    logic                 r_first, n_first;
    logic [HW-1:0]        r_h,     n_h;
    logic [CW-1:0]        r_start, n_start;
    logic [mra_pkg::AREA_W-1:0] r_best, n_best;
    logic                       r_out_valid, n_out_valid;
    logic [mra_pkg::AREA_W-1:0] r_out_area,  n_out_area;

    logic                 w_deq;
    logic                 w_hwe;
    logic                 w_push_we;
    logic                 w_clear;
    logic [CW-1:0]        w_rd_addr;
    logic [HW:0]          w_sum;
    logic [HW-1:0]        w_hbase;
    logic [HW-1:0]        w_hnew;
    logic [HW-1:0]        w_hcur;
    logic                 w_off_en;
    logic [HW-1:0]        w_oh;
    logic [DW-1:0]        w_ow;
    logic [PW-1:0]        w_prod;
    logic [XW-1:0]        w_ext;
    logic [mra_pkg::AREA_W-1:0] w_area;

    assign o_valid    = r_out_valid;
    assign o_max_area = r_out_area;
    assign o_q_pop    = w_deq;

    // New run height from the column's stored height
    assign w_hbase = r_hrd_vld ? r_hrd : '0;
    assign w_sum   = {1'b0, w_hbase} + (HW + 1)'(1);
    always_comb begin
        if (!r_item.cell_bit) begin
            w_hnew = '0;
        end else if (w_sum > (HW + 1)'(MAX_ROWS)) begin
            w_hnew = HW'(MAX_ROWS);
        end else begin
            w_hnew = w_sum[HW-1:0];
        end
    end
    assign w_hcur = r_first ? w_hnew : r_h;

    // Area offer: one multiply, saturate, keep the best
    assign w_prod = PW'(w_oh) * PW'(w_ow);
    assign w_ext  = XW'(w_prod);
    assign w_area = (w_ext > XW'(mra_pkg::AREA_CAP)) ? mra_pkg::AREA_CAP
                                                     : w_ext[mra_pkg::AREA_W-1:0];

    // Control sequencer
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_col       = r_col;
        n_first     = r_first;
        n_h         = r_h;
        n_start     = r_start;
        n_top_s     = r_top_s;
        n_top_h     = r_top_h;
        n_depth     = r_depth;
        n_best      = r_best;
        n_out_valid = r_out_valid;
        n_out_area  = r_out_area;
        w_deq       = 1'b0;
        w_hwe       = 1'b0;
        w_push_we   = 1'b0;
        w_clear     = 1'b0;
        w_off_en    = 1'b0;
        w_oh        = r_top_h;
        w_ow        = '0;

        // output register drains independently
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mra_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    w_deq   = 1'b1;
                    n_item  = i_q_item;
                    n_first = 1'b1;
                    n_start = r_col;
                    n_state = mra_pkg::ST_SCAN;
                end
            end

            mra_pkg::ST_SCAN: begin
                w_hwe   = r_first;
                n_first = 1'b0;
                n_h     = w_hcur;
                if (r_depth != '0 && r_top_h >= w_hcur) begin
                    // pop a bar no shorter than this one, closing at this column
                    w_off_en = 1'b1;
                    w_ow     = DW'(r_col) - DW'(r_top_s);
                    n_start  = r_top_s;
                    n_depth  = r_depth - 1'b1;
                    n_top_s  = r_below_s;
                    n_top_h  = r_below_h;
                end else begin
                    if (r_depth != DW'(MAX_COLS)) begin
                        w_push_we = 1'b1;
                        n_depth   = r_depth + 1'b1;
                        n_top_s   = r_start;
                        n_top_h   = w_hcur;
                    end
                    if (r_item.row_end) begin
                        n_state = mra_pkg::ST_FLUSH;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_state = mra_pkg::ST_IDLE;
                    end
                end
            end

            mra_pkg::ST_FLUSH: begin
                if (r_depth != '0) begin
                    w_off_en = 1'b1;
                    w_ow     = DW'(r_col) + DW'(1) - DW'(r_top_s);
                    n_depth  = r_depth - 1'b1;
                    n_top_s  = r_below_s;
                    n_top_h  = r_below_h;
                end else begin
                    n_col   = '0;
                    n_state = r_item.last_cell ? mra_pkg::ST_OUT : mra_pkg::ST_IDLE;
                end
            end

            mra_pkg::ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_area  = r_best;
                    n_best      = '0;
                    n_depth     = '0;
                    w_clear     = 1'b1;
                    n_state     = mra_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = mra_pkg::ST_IDLE;
            end
        endcase

        if (w_off_en && w_area > r_best) begin
            n_best = w_area;
        end
    end

    // Stack read keeps the entry below the next top
    assign w_rd_addr = CW'(n_depth - DW'(2));

    always_ff @(posedge i_clk) begin
        if (w_push_we) begin
            r_smem_s[r_depth[CW-1:0]] <= r_start;
            r_smem_h[r_depth[CW-1:0]] <= w_hcur;
        end
        r_below_s <= r_smem_s[w_rd_addr];
        r_below_h <= r_smem_h[w_rd_addr];
    end

    // Height memory: read on dequeue, write on the first scan beat
    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_hmem[r_col] <= w_hnew;
        end
        if (w_deq) begin
            r_hrd <= r_hmem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid  <= '0;
            r_hrd_vld <= 1'b0;
        end else begin
            if (w_clear) begin
                r_hvalid <= '0;
            end else if (w_hwe) begin
                r_hvalid[r_col] <= 1'b1;
            end
            if (w_deq) begin
                r_hrd_vld <= r_hvalid[r_col];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mra_pkg::ST_IDLE;
            r_col       <= '0;
            r_depth     <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_depth     <= n_depth;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_h        <= n_h;
        r_start    <= n_start;
        r_top_s    <= n_top_s;
        r_top_h    <= n_top_h;
        r_out_area <= n_out_area;
    end

endmodule

### src/max_ones_rectangle_area.sv
// Largest all-ones rectangle in a binary matrix streamed one cell per beat.
//
// Cell channel (i_valid/o_ready): i_cell_bit and i_last_cell, row-major order.
// Config channel (i_cfg_valid/o_cfg_ready): i_row_width, columns per row;
// write it only while the block is idle. Zero reads as one, values above
// MAX_COLS read as MAX_COLS. Reset value is 64.
// Result channel (o_valid/i_ready): o_max_area, one beat per last cell.
//
// A front stage tracks the column and tags row ends; a 4-entry queue feeds
// the back stage, which runs the height table and the bar stack.
// Each cell is dequeued in IDLE; SCAN then pops bars no shorter than it, one
// stack compare per cycle, and pushes the cell. A row end then pops every bar
// left on the stack in FLUSH, and the last cell loads the result in OUT.
// Each cell is pushed once and popped once. Cells waiting in the queue and
// bars to pop delay the result.
// The front keeps accepting cells until the queue is full.
// A result waiting on a stalled receiver does not block new cells; the next
// matrix stalls only when its own result is due.
// Reset is synchronous: row width returns to 64, heights, stack and best area
// clear at once (per-column valid bits, no clearing pass).
module max_ones_rectangle_area #(
    parameter int MAX_COLS = mra_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mra_pkg::MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cell_bit,
    input  logic                       i_last_cell,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mra_pkg::ROW_W-1:0]  i_row_width,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mra_pkg::AREA_W-1:0] o_max_area
);

    mra_pkg::t_item w_push_item;
    mra_pkg::t_item w_head_item;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;

    mra_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cell_bit  (i_cell_bit),
        .i_last_cell (i_last_cell),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_row_width (i_row_width),
        .i_q_full    (w_full),
        .o_q_push    (w_push),
        .o_q_item    (w_push_item)
    );

    mra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_head_item)
    );

    mra_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_empty),
        .i_q_item   (w_head_item),
        .o_q_pop    (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_max_area (o_max_area)
    );

endmodule

### src/mra_checker.sv
module mra_checker #(
    parameter int MAX_COLS = mra_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mra_pkg::MAX_ROWS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_cfg_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [mra_pkg::AREA_W-1:0] o_max_area
);

    localparam longint AREA_BOUND = longint'(MAX_ROWS) * longint'(MAX_COLS);

    // A stalled result beat holds its area
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_max_area))
        else $error("result beat dropped or changed while stalled");

    // No rectangle can exceed the full matrix
    a_area_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (longint'(o_max_area) <= AREA_BOUND))
        else $error("area larger than MAX_ROWS * MAX_COLS");

    // The cell channel only backs off after taking a beat
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid && o_ready))
        else $error("cell channel stalled without a beat taken");

    // A result beat never carries unknown bits
    a_area_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_max_area))
        else $error("result beat with unknown area");

    // Config writes are always taken
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config channel not ready");

endmodule

bind max_ones_rectangle_area mra_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
) u_mra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_cfg_ready (o_cfg_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_max_area  (o_max_area)
);
